// ===== hw/rtl/chaikin_polyline_refine_coarsen_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef CHAIKIN_POLYLINE_REFINE_COARSEN_DEFINES_SVH
`define CHAIKIN_POLYLINE_REFINE_COARSEN_DEFINES_SVH

`ifndef ASSERT_OFF
`define CPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CPRC_ASSERT_ALW(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");
`else
`define CPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPRC_ASSERT_ALW(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/cprc_pkg.sv =====
package cprc_pkg;

    localparam int PT_W           = 32;
    localparam int CNT_W          = 13;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int LEVEL_MAX_DEF  = 15;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // queue entry kinds
    localparam logic OP_EMIT  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    // configuration register indexes
    localparam logic CFG_DIRECTION   = 1'b0;
    localparam logic CFG_POINT_COUNT = 1'b1;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } t_point;

    // BLEND: results Q, R, then p when eol. EMIT: result p with eol.
    typedef struct packed {
        logic   op;
        logic   eol;
        t_point p;
        t_point h;
    } t_entry;

endpackage

// ===== hw/rtl/cprc_in_if.sv =====
interface cprc_in_if import cprc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] pos_x;
    logic signed [PT_W-1:0] pos_y;
    logic signed [PT_W-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== hw/rtl/cprc_out_if.sv =====
interface cprc_out_if import cprc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] out_x;
    logic signed [PT_W-1:0] out_y;
    logic signed [PT_W-1:0] out_z;
    logic                   end_of_line;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output end_of_line, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input end_of_line, output ready);
endinterface

// ===== hw/rtl/cprc_front.sv =====
module cprc_front import cprc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int LEVEL_MAX  = LEVEL_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    cprc_in_if.sink          i_pt,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int LVL_W = $clog2(LEVEL_MAX + 1);

    logic             r_dir;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [LVL_W-1:0] r_level, n_level;
    t_point           r_held, n_held;

    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] final_odd;
    logic             accept;
    logic             last;
    logic             coarse_ok;
    t_point           pin;
    t_point           pq;

    function automatic logic signed [PT_W-1:0] coarse(
        input logic signed [PT_W-1:0] p,
        input logic signed [PT_W-1:0] h
    );
        logic signed [PT_W+2:0] pe;
        logic signed [PT_W+2:0] he;
        logic signed [PT_W+2:0] d;
        pe = {{3{p[PT_W-1]}}, p};
        he = {{3{h[PT_W-1]}}, h};
        d  = (pe <<< 2) - (he <<< 1) - he;
        if (d > $signed({4'b0000, {(PT_W-1){1'b1}}})) begin
            coarse = {1'b0, {(PT_W-1){1'b1}}};
        end else if (d < $signed({4'b1111, {(PT_W-1){1'b0}}})) begin
            coarse = {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            coarse = d[PT_W-1:0];
        end
    endfunction

    assign pin.x = i_pt.pos_x;
    assign pin.y = i_pt.pos_y;
    assign pin.z = i_pt.pos_z;

    assign pq.x = coarse(pin.x, r_held.x);
    assign pq.y = coarse(pin.y, r_held.y);
    assign pq.z = coarse(pin.z, r_held.z);

    always_comb begin
        if (r_cnt < CNT_W'(2)) begin
            cnt_eff = CNT_W'(2);
        end else if (32'(r_cnt) > 32'(MAX_POINTS)) begin
            cnt_eff = CNT_W'(MAX_POINTS);
        end else begin
            cnt_eff = r_cnt;
        end
    end

    assign i_pt.ready = !i_q_full;
    assign accept     = i_pt.valid && !i_q_full;
    assign last       = (r_idx >= cnt_eff - 1'b1);
    assign coarse_ok  = (r_level != '0) && (cnt_eff > CNT_W'(4));
    assign final_odd  = cnt_eff[0] ? cnt_eff - CNT_W'(2) : cnt_eff - CNT_W'(3);

    always_comb begin
        o_push        = 1'b0;
        o_entry.op    = OP_EMIT;
        o_entry.eol   = 1'b0;
        o_entry.p     = pin;
        o_entry.h     = r_held;
        n_idx         = r_idx;
        n_level       = r_level;
        n_held        = r_held;
        if (accept) begin
            n_idx = last ? '0 : r_idx + 1'b1;
            if (!r_dir) begin
                o_push      = 1'b1;
                o_entry.op  = (r_idx == '0) ? OP_EMIT : OP_BLEND;
                o_entry.eol = last;
                n_held      = pin;
                if (last && (r_level < LVL_W'(LEVEL_MAX))) begin
                    n_level = r_level + 1'b1;
                end
            end else if (!coarse_ok) begin
                o_push      = 1'b1;
                o_entry.eol = last;
            end else begin
                if (r_idx == '0) begin
                    o_push = 1'b1;
                    n_held = pin;
                end else if (!last && r_idx[0]) begin
                    o_push      = 1'b1;
                    o_entry.p   = pq;
                    o_entry.eol = (r_idx == final_odd);
                    n_held      = pq;
                end
                if (last) begin
                    n_level = r_level - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_cnt   <= CNT_W'(2);
            r_idx   <= '0;
            r_level <= '0;
            r_held  <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_DIRECTION)) begin
                r_dir <= i_cfg_data[0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_POINT_COUNT)) begin
                r_cnt <= i_cfg_data;
            end
            r_idx   <= n_idx;
            r_level <= n_level;
            r_held  <= n_held;
        end
    end

endmodule

// ===== hw/rtl/cprc_queue.sv =====
module cprc_queue import cprc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_entry            i_wdata,
    input  logic              i_pop,
    output t_entry            o_rdata,
    output logic              o_full,
    output logic              o_empty,
    output logic [QCNT_W-1:0] o_cnt
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/cprc_back.sv =====
module cprc_back import cprc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_entry,
    input  logic      i_empty,
    output logic      o_pop,
    cprc_out_if.source o_res
);

    localparam logic [1:0] PH_Q = 2'd0;
    localparam logic [1:0] PH_R = 2'd1;
    localparam logic [1:0] PH_P = 2'd2;

    logic [1:0] r_phase;
    logic       r_valid;
    logic       r_eol;
    t_point     r_out;

    t_point     q, r, res;
    logic       res_eol;
    logic       fin;
    logic       load;
    logic       avail;

    // floor((3a + b + 2) / 4), always in range
    function automatic logic signed [PT_W-1:0] blend(
        input logic signed [PT_W-1:0] a,
        input logic signed [PT_W-1:0] b
    );
        logic signed [PT_W+2:0] ae;
        logic signed [PT_W+2:0] be;
        logic signed [PT_W+2:0] s;
        ae    = {{3{a[PT_W-1]}}, a};
        be    = {{3{b[PT_W-1]}}, b};
        s     = ae + (ae <<< 1) + be + (PT_W+3)'(2);
        blend = s[PT_W+1:2];
    endfunction

    assign q.x = blend(i_entry.h.x, i_entry.p.x);
    assign q.y = blend(i_entry.h.y, i_entry.p.y);
    assign q.z = blend(i_entry.h.z, i_entry.p.z);
    assign r.x = blend(i_entry.p.x, i_entry.h.x);
    assign r.y = blend(i_entry.p.y, i_entry.h.y);
    assign r.z = blend(i_entry.p.z, i_entry.h.z);

    always_comb begin
        res     = i_entry.p;
        res_eol = i_entry.eol;
        fin     = 1'b1;
        if (i_entry.op == OP_BLEND) begin
            case (r_phase)
                PH_Q: begin
                    res     = q;
                    res_eol = 1'b0;
                    fin     = 1'b0;
                end
                PH_R: begin
                    res     = r;
                    res_eol = 1'b0;
                    fin     = !i_entry.eol;
                end
                default: begin
                    res     = i_entry.p;
                    res_eol = 1'b1;
                    fin     = 1'b1;
                end
            endcase
        end
    end

    assign load  = !r_valid || o_res.ready;
    assign avail = !i_empty;
    assign o_pop = load && avail && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_Q;
        end else if (load) begin
            r_valid <= avail;
            if (avail) begin
                r_phase <= fin ? PH_Q : ((r_phase == PH_Q) ? PH_R : PH_P);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && avail) begin
            r_out <= res;
            r_eol <= res_eol;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.out_x       = r_out.x;
    assign o_res.out_y       = r_out.y;
    assign o_res.out_z       = r_out.z;
    assign o_res.end_of_line = r_eol;

endmodule

// ===== hw/rtl/chaikin_polyline_refine_coarsen.sv =====
// Streams one pass of a 3-D polyline in signed Q16.16, refining it by Chaikin
// corner cutting (direction 0) or coarsening a refined line back (direction 1),
// with a pass-through when coarsening is not allowed. A point is taken in
// every cycle while the four-item queue between the classifier and the
// emitter has room; results leave one per cycle from an output register
// while the receiver is ready. Refine gives one result for the first point,
// two for each later point and three for the last, so a refine pass is
// limited by the emitter; coarsen and pass-through give at most one result
// per point. Write direction and point_count only while the block is idle.
`include "chaikin_polyline_refine_coarsen_defines.svh"

module chaikin_polyline_refine_coarsen import cprc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int LEVEL_MAX  = LEVEL_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    cprc_in_if.sink          i_pt,
    cprc_out_if.source       o_res
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic [QCNT_W-1:0] q_cnt;
    t_entry            wr_entry;
    t_entry            rd_entry;

    cprc_front #(
        .MAX_POINTS (MAX_POINTS),
        .LEVEL_MAX  (LEVEL_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (i_pt),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (wr_entry)
    );

    cprc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .i_pop   (pop),
        .o_rdata (rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cnt   (q_cnt)
    );

    cprc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (rd_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    `CPRC_ASSERT_ALW(a_q_bound, i_clk, i_rst_n, q_cnt <= QCNT_W'(QDEPTH))
    `CPRC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, push, !q_full)
    `CPRC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, pop, q_cnt != '0)

endmodule
